// ----- rtl/core/spff_pkg.sv -----
package spff_pkg;

    // Fixed limits and field widths.
    localparam int PWM_LIMIT          = 3599;
    localparam int INTEGRAL_LIMIT_DEF = 1000;

    localparam int TGT_W    = 20;
    localparam int ERR_W    = 21;
    localparam int MAG_W    = 20;
    localparam int GAIN_W   = 24;
    localparam int CMD_W    = 13;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    // Datapath sizing.
    localparam int PROD_W    = GAIN_W + MAG_W;
    localparam int NUM_W     = 36;
    localparam int RDX_W     = 4;
    localparam int DIGITS    = NUM_W / RDX_W;
    localparam int DIVR_W    = 6;
    localparam int RX_W      = DIVR_W + RDX_W;
    localparam int CNT_W     = 4;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = 40;
    localparam int SEG_W     = 3;
    localparam int FF_BASE_W = 28;
    localparam int FF_K_W    = 16;
    localparam int PC_W      = 4;

    // The integral step divides by 12800; the low 8 bits are dropped first.
    localparam logic [DIVR_W-1:0] I_DIVISOR = DIVR_W'(50);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN,
        REG_KI_GAIN
    } cfg_reg_t;

    typedef enum logic [3:0] {
        U_IDLE,
        U_PREP,
        U_SEG,
        U_MUL_FF,
        U_DSTEP,
        U_FF_DONE,
        U_MUL_P,
        U_P_ADD,
        U_BEFORE,
        U_MUL_I,
        U_INT_ADD,
        U_RAW,
        U_CLEAR,
        U_OUT
    } uop_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_CLEAR,
        JC_DIV_MORE,
        JC_HOLD
    } jc_t;

    typedef struct packed {
        uop_t            op;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_IDLE    = PC_W'(0);
    localparam logic [PC_W-1:0] PC_PREP    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SEG     = PC_W'(2);
    localparam logic [PC_W-1:0] PC_MUL_FF  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_DIV_FF  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_FF_DONE = PC_W'(5);
    localparam logic [PC_W-1:0] PC_MUL_P   = PC_W'(6);
    localparam logic [PC_W-1:0] PC_P_ADD   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_BEFORE  = PC_W'(8);
    localparam logic [PC_W-1:0] PC_MUL_I   = PC_W'(9);
    localparam logic [PC_W-1:0] PC_DIV_I   = PC_W'(10);
    localparam logic [PC_W-1:0] PC_INT_ADD = PC_W'(11);
    localparam logic [PC_W-1:0] PC_RAW     = PC_W'(12);
    localparam logic [PC_W-1:0] PC_CLEAR   = PC_W'(13);
    localparam logic [PC_W-1:0] PC_OUT     = PC_W'(14);

    // Control store. Without a stall or a taken jump the program advances by one.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{U_IDLE, JC_ALWAYS, PC_IDLE};
        case (pc)
            PC_IDLE:    w = '{U_IDLE,    JC_NONE,     PC_IDLE};
            PC_PREP:    w = '{U_PREP,    JC_CLEAR,    PC_CLEAR};
            PC_SEG:     w = '{U_SEG,     JC_NONE,     PC_IDLE};
            PC_MUL_FF:  w = '{U_MUL_FF,  JC_NONE,     PC_IDLE};
            PC_DIV_FF:  w = '{U_DSTEP,   JC_DIV_MORE, PC_DIV_FF};
            PC_FF_DONE: w = '{U_FF_DONE, JC_NONE,     PC_IDLE};
            PC_MUL_P:   w = '{U_MUL_P,   JC_NONE,     PC_IDLE};
            PC_P_ADD:   w = '{U_P_ADD,   JC_NONE,     PC_IDLE};
            PC_BEFORE:  w = '{U_BEFORE,  JC_NONE,     PC_IDLE};
            PC_MUL_I:   w = '{U_MUL_I,   JC_HOLD,     PC_RAW};
            PC_DIV_I:   w = '{U_DSTEP,   JC_DIV_MORE, PC_DIV_I};
            PC_INT_ADD: w = '{U_INT_ADD, JC_NONE,     PC_IDLE};
            PC_RAW:     w = '{U_RAW,     JC_ALWAYS,   PC_OUT};
            PC_CLEAR:   w = '{U_CLEAR,   JC_NONE,     PC_IDLE};
            PC_OUT:     w = '{U_OUT,     JC_ALWAYS,   PC_IDLE};
            default:    w = '{U_IDLE,    JC_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

    typedef struct packed {
        logic [FF_BASE_W-1:0] base;
        logic [MAG_W-1:0]     off;
        logic [FF_K_W-1:0]    k;
        logic [DIVR_W-1:0]    dv;
    } ff_seg_t;

    // Feedforward segment for a target magnitude in Q.8 RPM.
    function automatic logic [SEG_W-1:0] ff_seg_of(input logic [MAG_W-1:0] a);
        logic [SEG_W-1:0] s;
        if (a <= MAG_W'(10240)) begin
            s = SEG_W'(0);
        end else if (a <= MAG_W'(12032)) begin
            s = SEG_W'(1);
        end else if (a <= MAG_W'(13952)) begin
            s = SEG_W'(2);
        end else if (a <= MAG_W'(14208)) begin
            s = SEG_W'(3);
        end else if (a <= MAG_W'(16512)) begin
            s = SEG_W'(4);
        end else begin
            s = SEG_W'(5);
        end
        return s;
    endfunction

    // Each segment is base + k * (a - off) / dv in Q.16 counts.
    function automatic ff_seg_t ff_seg_row(input logic [SEG_W-1:0] s);
        ff_seg_t r;
        case (s)
            SEG_W'(0): r = '{FF_BASE_W'(0), MAG_W'(0),
                             FF_K_W'(13760), DIVR_W'(1)};
            SEG_W'(1): r = '{FF_BASE_W'(2150 << FRAC_W), MAG_W'(10240),
                             FF_K_W'(64000), DIVR_W'(7)};
            SEG_W'(2): r = '{FF_BASE_W'(2400 << FRAC_W), MAG_W'(12032),
                             FF_K_W'(20480), DIVR_W'(3)};
            SEG_W'(3): r = '{FF_BASE_W'(2600 << FRAC_W), MAG_W'(13952),
                             FF_K_W'(10752), DIVR_W'(1)};
            SEG_W'(4): r = '{FF_BASE_W'(2642 << FRAC_W), MAG_W'(14208),
                             FF_K_W'(40448), DIVR_W'(9)};
            default:   r = '{FF_BASE_W'(2800 << FRAC_W), MAG_W'(16512),
                             FF_K_W'(16256), DIVR_W'(5)};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/speed_pi_with_feedforward_unit.sv -----
// Channel  Direction  Handshake             Contents
// s_       in         s_tvalid / s_tready   speed_target, speed_measured, clear_memory
// m_       out        m_tvalid / m_tready   pwm_command, output_saturated
// cfg_     in         cfg_wr_en             kp_gain (index 0), ki_gain (index 1)
//
// Each request runs through the microcode program; the integral division is skipped when
// the integral is held by the saturation rule, and a clear request skips to the clear step.
// The program shares one 24x20 multiplier, and a normal request runs two nine-digit
// radix-16 divisions by a constant on one shared divider.
// Reset (aresetn low, synchronous) clears the gains, the integral and the program counter.
// A result waits in the output register; the program stalls at its last step while
// that register is full and m_tready is low, and accepts no request until it moves on.
module speed_pi_with_feedforward_unit #(
    parameter int INTEGRAL_LIMIT = spff_pkg::INTEGRAL_LIMIT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [19:0] speed_target, [39:20] speed_measured, [40] clear_memory, [47:41] zero
    input  logic [spff_pkg::S_DATA_W-1:0]  s_tdata,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [12:0] pwm_command, [13] output_saturated, [15:14] zero
    output logic [spff_pkg::M_DATA_W-1:0]  m_tdata,

    input  logic                           cfg_wr_en,
    input  logic [spff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spff_pkg::GAIN_W-1:0]    cfg_wr_data
);

    localparam int TGT_W    = spff_pkg::TGT_W;
    localparam int ERR_W    = spff_pkg::ERR_W;
    localparam int MAG_W    = spff_pkg::MAG_W;
    localparam int GAIN_W   = spff_pkg::GAIN_W;
    localparam int CMD_W    = spff_pkg::CMD_W;
    localparam int M_DATA_W = spff_pkg::M_DATA_W;
    localparam int PROD_W   = spff_pkg::PROD_W;
    localparam int NUM_W    = spff_pkg::NUM_W;
    localparam int RDX_W    = spff_pkg::RDX_W;
    localparam int DIVR_W   = spff_pkg::DIVR_W;
    localparam int RX_W     = spff_pkg::RX_W;
    localparam int CNT_W    = spff_pkg::CNT_W;
    localparam int FRAC_W   = spff_pkg::FRAC_W;
    localparam int ACC_W    = spff_pkg::ACC_W;
    localparam int SEG_W    = spff_pkg::SEG_W;
    localparam int PC_W     = spff_pkg::PC_W;

    localparam int INT_W = $clog2(INTEGRAL_LIMIT + 1) + FRAC_W + 1;

    localparam logic signed [ACC_W-1:0] LIM_Q16  =
        ACC_W'(longint'(spff_pkg::PWM_LIMIT) << FRAC_W);
    localparam logic signed [ACC_W-1:0] NLIM_Q16 = -LIM_Q16;
    localparam logic signed [ACC_W-1:0] ILIM_Q16 =
        ACC_W'(longint'(INTEGRAL_LIMIT) << FRAC_W);
    localparam logic signed [ACC_W-1:0] NILIM_Q16 = -ILIM_Q16;
    localparam logic signed [ACC_W-1:0] RND_Q16  = ACC_W'((1 << FRAC_W) - 1);

    // Control state.
    logic [PC_W-1:0]         pc_reg;
    logic [PC_W-1:0]         pc_next;
    logic                    m_tvalid_reg;
    logic [GAIN_W-1:0]       kp_reg;
    logic [GAIN_W-1:0]       ki_reg;
    logic signed [INT_W-1:0] integ_reg;
    logic signed [INT_W-1:0] integ_next;
    logic [CNT_W-1:0]        cnt_reg;

    // Datapath registers.
    logic signed [TGT_W-1:0] t_reg;
    logic signed [TGT_W-1:0] m_reg;
    logic                    clr_reg;
    logic signed [ERR_W-1:0] e_reg;
    logic signed [ERR_W-1:0] e_next;
    logic [MAG_W-1:0]        a_reg;
    logic [MAG_W-1:0]        a_next;
    logic [MAG_W-1:0]        emag_reg;
    logic [MAG_W-1:0]        emag_next;
    logic [SEG_W-1:0]        seg_reg;
    logic [SEG_W-1:0]        seg_next;
    logic [MAG_W-1:0]        d_reg;
    logic [MAG_W-1:0]        d_next;
    logic [NUM_W-1:0]        num_reg;
    logic [NUM_W-1:0]        num_next;
    logic [DIVR_W-1:0]       rem_reg;
    logic [DIVR_W-1:0]       rem_next;
    logic [DIVR_W-1:0]       div_reg;
    logic signed [ACC_W-1:0] ff_reg;
    logic signed [ACC_W-1:0] ff_next;
    logic [NUM_W-1:0]        p_reg;
    logic signed [ACC_W-1:0] fp_reg;
    logic signed [ACC_W-1:0] fp_next;
    logic                    allow_reg;
    logic                    allow_next;
    logic signed [ACC_W-1:0] raw_reg;
    logic signed [ACC_W-1:0] raw_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic [CMD_W-1:0]        out_cmd_reg;
    logic [CMD_W-1:0]        cmd_next;
    logic                    out_sat_reg;

    // Combinational helpers.
    spff_pkg::ctrl_word_t    ctl;
    spff_pkg::ff_seg_t       seg_row;
    spff_pkg::ff_seg_t       seg_row_next;
    logic                    out_busy;
    logic                    stall;
    logic                    jump;
    logic [GAIN_W-1:0]       mul_a;
    logic [MAG_W-1:0]        mul_b;
    logic [PROD_W-1:0]       mul_prod;
    logic [RX_W-1:0]         rx;
    logic [RDX_W-1:0]        digit;
    logic                    t_neg;
    logic                    e_neg;
    logic signed [ERR_W-1:0] t_wide;
    logic signed [ACC_W-1:0] integ_ext;
    logic signed [ACC_W-1:0] ff_sum;
    logic signed [ACC_W-1:0] p_ext;
    logic signed [ACC_W-1:0] q_ext;
    logic signed [ACC_W-1:0] pre_sum;
    logic signed [ACC_W-1:0] i_sum;
    logic signed [ACC_W-1:0] raw_sum;
    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] cmd_wide;

    // Sequencer.
    always_comb begin
        ctl      = spff_pkg::ucode(pc_reg);
        out_busy = m_tvalid_reg && !m_tready;
        stall    = ((ctl.op == spff_pkg::U_IDLE) && !s_tvalid) ||
                   ((ctl.op == spff_pkg::U_OUT) && out_busy);
        case (ctl.jc)
            spff_pkg::JC_NONE:     jump = 1'b0;
            spff_pkg::JC_ALWAYS:   jump = 1'b1;
            spff_pkg::JC_CLEAR:    jump = clr_reg || (t_reg == '0);
            spff_pkg::JC_DIV_MORE: jump = (cnt_reg != CNT_W'(spff_pkg::DIGITS - 1));
            spff_pkg::JC_HOLD:     jump = !allow_reg;
            default:               jump = 1'b0;
        endcase
        if (stall) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = ctl.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // Shared multiplier: feedforward slope, P gain or I gain against a magnitude.
    always_comb begin
        seg_row = spff_pkg::ff_seg_row(seg_reg);
        case (ctl.op)
            spff_pkg::U_MUL_P: begin
                mul_a = kp_reg;
                mul_b = emag_reg;
            end
            spff_pkg::U_MUL_I: begin
                mul_a = ki_reg;
                mul_b = emag_reg;
            end
            default: begin
                mul_a = GAIN_W'(seg_row.k);
                mul_b = d_reg;
            end
        endcase
        mul_prod = mul_a * mul_b;
    end

    // Radix-16 long division by a small constant, one digit per step. The
    // numerator shifts out at the top while quotient digits shift in below.
    always_comb begin
        rx    = {rem_reg, num_reg[NUM_W-1 -: RDX_W]};
        digit = '0;
        for (int k = 1; k < (1 << RDX_W); k++) begin
            if (rx >= RX_W'(k) * RX_W'(div_reg)) begin
                digit = RDX_W'(k);
            end
        end
        rem_next = DIVR_W'(rx - RX_W'(digit) * RX_W'(div_reg));
        num_next = {num_reg[NUM_W-RDX_W-1:0], digit};
    end

    // Arithmetic for the remaining steps.
    always_comb begin
        t_neg        = t_reg[TGT_W-1];
        e_neg        = e_reg[ERR_W-1];
        t_wide       = ERR_W'(t_reg);
        e_next       = ERR_W'(t_reg) - ERR_W'(m_reg);
        a_next       = MAG_W'(t_neg ? -t_wide : t_wide);
        emag_next    = MAG_W'(e_neg ? -e_reg : e_reg);
        seg_next     = spff_pkg::ff_seg_of(a_reg);
        seg_row_next = spff_pkg::ff_seg_row(seg_next);
        d_next       = a_reg - seg_row_next.off;

        ff_sum  = ACC_W'(seg_row.base) + ACC_W'(num_reg);
        ff_next = (ff_sum > LIM_Q16) ? LIM_Q16 : ff_sum;

        // Feedforward takes the sign of the target and P the sign of the error.
        p_ext   = signed'(ACC_W'(p_reg));
        fp_next = (t_neg ? -ff_reg : ff_reg) + (e_neg ? -p_ext : p_ext);

        integ_ext  = ACC_W'(integ_reg);
        pre_sum    = fp_reg + integ_ext;
        allow_next = ((pre_sum > NLIM_Q16) && (pre_sum < LIM_Q16)) ||
                     ((pre_sum >= LIM_Q16) && e_neg) ||
                     ((pre_sum <= NLIM_Q16) && !e_neg);

        q_ext = signed'(ACC_W'(num_reg));
        i_sum = integ_ext + (e_neg ? -q_ext : q_ext);
        if (i_sum > ILIM_Q16) begin
            integ_next = INT_W'(ILIM_Q16);
        end else if (i_sum < NILIM_Q16) begin
            integ_next = INT_W'(NILIM_Q16);
        end else begin
            integ_next = INT_W'(i_sum);
        end

        raw_sum = fp_reg + integ_ext;
        if (raw_sum > LIM_Q16) begin
            raw_next = LIM_Q16;
            sat_next = 1'b1;
        end else if (raw_sum < NLIM_Q16) begin
            raw_next = NLIM_Q16;
            sat_next = 1'b1;
        end else begin
            raw_next = raw_sum;
            sat_next = 1'b0;
        end

        // Adding the fraction mask before the arithmetic shift rounds toward zero.
        rnd_sum  = raw_reg + (raw_reg[ACC_W-1] ? RND_Q16 : ACC_W'(0));
        cmd_wide = rnd_sum >>> FRAC_W;
        cmd_next = cmd_wide[CMD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= spff_pkg::PC_IDLE;
            m_tvalid_reg <= 1'b0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            integ_reg    <= '0;
            cnt_reg      <= '0;
        end else begin
            pc_reg <= pc_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    spff_pkg::REG_KP_GAIN: kp_reg <= cfg_wr_data;
                    spff_pkg::REG_KI_GAIN: ki_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if ((ctl.op == spff_pkg::U_OUT) && !out_busy) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (ctl.op)
                spff_pkg::U_MUL_FF,
                spff_pkg::U_MUL_I:   cnt_reg   <= '0;
                spff_pkg::U_DSTEP:   cnt_reg   <= cnt_reg + 1'b1;
                spff_pkg::U_INT_ADD: integ_reg <= integ_next;
                spff_pkg::U_CLEAR:   integ_reg <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctl.op)
            spff_pkg::U_IDLE: begin
                if (s_tvalid) begin
                    t_reg   <= s_tdata[TGT_W-1:0];
                    m_reg   <= s_tdata[2*TGT_W-1:TGT_W];
                    clr_reg <= s_tdata[2*TGT_W];
                end
            end
            spff_pkg::U_PREP: begin
                e_reg <= e_next;
                a_reg <= a_next;
            end
            spff_pkg::U_SEG: begin
                seg_reg  <= seg_next;
                d_reg    <= d_next;
                emag_reg <= emag_next;
            end
            spff_pkg::U_MUL_FF: begin
                num_reg <= mul_prod[NUM_W-1:0];
                rem_reg <= '0;
                div_reg <= seg_row.dv;
            end
            spff_pkg::U_DSTEP: begin
                num_reg <= num_next;
                rem_reg <= rem_next;
            end
            spff_pkg::U_FF_DONE: ff_reg <= ff_next;
            // The top bits of the product are the gain term with 8 bits dropped.
            spff_pkg::U_MUL_P:   p_reg <= mul_prod[PROD_W-1 -: NUM_W];
            spff_pkg::U_P_ADD:   fp_reg <= fp_next;
            spff_pkg::U_BEFORE:  allow_reg <= allow_next;
            spff_pkg::U_MUL_I: begin
                num_reg <= mul_prod[PROD_W-1 -: NUM_W];
                rem_reg <= '0;
                div_reg <= spff_pkg::I_DIVISOR;
            end
            spff_pkg::U_RAW: begin
                raw_reg <= raw_next;
                sat_reg <= sat_next;
            end
            spff_pkg::U_CLEAR: begin
                raw_reg <= '0;
                sat_reg <= 1'b0;
            end
            spff_pkg::U_OUT: begin
                if (!out_busy) begin
                    out_cmd_reg <= cmd_next;
                    out_sat_reg <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    // No request is taken while reset is held.
    assign s_tready = aresetn && (ctl.op == spff_pkg::U_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - CMD_W - 1){1'b0}}, out_sat_reg, out_cmd_reg};

    a_integ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_ext <= ILIM_Q16) && (integ_ext >= NILIM_Q16))
        else $error("integral left its clamp range");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == spff_pkg::U_DSTEP) |-> (rem_reg < div_reg))
        else $error("division remainder not below divisor");

    a_clear_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == spff_pkg::U_CLEAR) |=> ((integ_reg == '0) && (pc_reg == spff_pkg::PC_OUT)))
        else $error("clear request did not empty the integral");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_sat_reg) |->
            ((out_cmd_reg == CMD_W'(spff_pkg::PWM_LIMIT)) ||
             (out_cmd_reg == CMD_W'(-spff_pkg::PWM_LIMIT))))
        else $error("saturated result not at the limit");

endmodule

// ----- sim/tb_speed_pi_with_feedforward_unit.sv -----
`timescale 1ns / 1ps

module tb_speed_pi_with_feedforward_unit;

    localparam int TGT_W              = spff_pkg::TGT_W;
    localparam int CMD_W              = spff_pkg::CMD_W;
    localparam int GAIN_W             = spff_pkg::GAIN_W;
    localparam int S_DATA_W           = spff_pkg::S_DATA_W;
    localparam int M_DATA_W           = spff_pkg::M_DATA_W;
    localparam int CFG_IDX_W          = spff_pkg::CFG_IDX_W;
    localparam int PWM_LIMIT          = spff_pkg::PWM_LIMIT;
    localparam int INTEGRAL_LIMIT_DEF = spff_pkg::INTEGRAL_LIMIT_DEF;

    localparam int     ITEMS_PER_PHASE = 290;
    localparam int     PHASES          = 7;
    localparam int     DRAIN_CYCLES    = 40;
    localparam longint CYCLE_LIMIT     = 1000000;

    typedef struct {
        logic signed [TGT_W-1:0] tgt;
        logic signed [TGT_W-1:0] meas;
        logic                    clr;
    } speed_req_t;

    typedef struct {
        logic signed [CMD_W-1:0] pwm;
        logic                    sat;
    } pwm_result_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = spff_pkg::REG_KP_GAIN;
    logic [GAIN_W-1:0]      cfg_wr_data = '0;

    speed_req_t  pending_reqs[$];
    pwm_result_t expected_pwm[$];

    // Mirror of the block's gains and integrator.
    longint kp_gain_q16  = 0;
    longint ki_gain_q16  = 0;
    longint integral_q16 = 0;

    int     open_reqs    = 0;
    int     mismatches   = 0;
    int     tx_gap       = 0;
    int     tx_quiet     = 0;
    int     rx_stall     = 0;
    int     rx_quiet     = 0;
    int     cruise_target = 6000;
    longint cycle_count  = 0;

    speed_pi_with_feedforward_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Mostly short gaps, a few long ones, and now and then a quiet stretch.
    function automatic int idle_len(inout int quiet, input int quiet_max);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3) begin
            quiet = $urandom_range(quiet_max / 3, quiet_max);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [TGT_W-1:0] clamp_speed(input int v);
        if (v > 524287) begin
            return 20'h7FFFF;
        end else if (v < -524288) begin
            return 20'h80000;
        end
        return TGT_W'(v);
    endfunction

    // Piecewise-linear feedforward in Q.16 counts, sign of the target applied.
    function automatic longint feedforward_q16(input longint t);
        longint a, f;
        a = (t < 0) ? -t : t;
        if (a <= 10240) begin
            f = 13760 * a;
        end else if (a <= 12032) begin
            f = (longint'(2150) << 16) + (64000 * (a - 10240)) / 7;
        end else if (a <= 13952) begin
            f = (longint'(2400) << 16) + (20480 * (a - 12032)) / 3;
        end else if (a <= 14208) begin
            f = (longint'(2600) << 16) + 10752 * (a - 13952);
        end else if (a <= 16512) begin
            f = (longint'(2642) << 16) + (40448 * (a - 14208)) / 9;
        end else begin
            f = (longint'(2800) << 16) + (16256 * (a - 16512)) / 5;
        end
        if (f > (longint'(PWM_LIMIT) << 16)) begin
            f = longint'(PWM_LIMIT) << 16;
        end
        return (t < 0) ? -f : f;
    endfunction

    function automatic pwm_result_t step_pwm(input speed_req_t r);
        longint t, m, e, ff, p, pre, sum, lim, ilim, cmd;
        bit allow;
        pwm_result_t res;
        lim  = longint'(PWM_LIMIT) << 16;
        ilim = longint'(INTEGRAL_LIMIT_DEF) << 16;
        t = r.tgt;
        m = r.meas;
        res.pwm = '0;
        res.sat = 1'b0;
        if (r.clr || t == 0) begin
            integral_q16 = 0;
            return res;
        end
        ff = feedforward_q16(t);
        e  = t - m;
        p  = kp_gain_q16 * e;
        p  = (p < 0) ? -((-p) >>> 8) : (p >>> 8);

        // The integrator only moves while unsaturated, or when the error
        // pulls the output back from the limit.
        pre = ff + p + integral_q16;
        allow = (pre > -lim && pre < lim) || (pre >= lim && e < 0) ||
                (pre <= -lim && e > 0);
        if (allow) begin
            // Signed division truncates toward zero.
            integral_q16 += (ki_gain_q16 * e) / 12800;
        end
        if (integral_q16 < -ilim) begin
            integral_q16 = -ilim;
        end else if (integral_q16 > ilim) begin
            integral_q16 = ilim;
        end

        sum = ff + p + integral_q16;
        if (sum > lim) begin
            sum = lim;
            res.sat = 1'b1;
        end else if (sum < -lim) begin
            sum = -lim;
            res.sat = 1'b1;
        end
        cmd = (sum < 0) ? -((-sum) >>> 16) : (sum >>> 16);
        res.pwm = cmd[CMD_W-1:0];
        return res;
    endfunction

    task automatic add_req(input int tgt, input int meas, input bit clr);
        speed_req_t r;
        r.tgt  = clamp_speed(tgt);
        r.meas = clamp_speed(meas);
        r.clr  = clr;
        pending_reqs.push_back(r);
        open_reqs++;
    endtask

    task automatic add_random_req();
        int r, spread, tgt, bp;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            add_req(int'(signed'(20'($urandom))), int'(signed'(20'($urandom))), 1'b1);
        end else if (r < 12) begin
            add_req(0, int'(signed'(20'($urandom))), 1'b0);
        end else if (r < 30) begin
            add_req(int'(signed'(20'($urandom))), int'(signed'(20'($urandom))), 1'b0);
        end else if (r < 42) begin
            case ($urandom_range(0, 6))
                0: bp = 10240;
                1: bp = 12032;
                2: bp = 13952;
                3: bp = 14208;
                4: bp = 16512;
                5: bp = 1;
                default: bp = 524287;
            endcase
            tgt = bp + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1)) begin
                tgt = -tgt;
            end
            add_req(tgt, tgt + $urandom_range(0, 800) - 400, 1'b0);
        end else begin
            // A held target with noisy feedback lets the integrator wind up.
            if ($urandom_range(0, 99) < 5) begin
                cruise_target = $urandom_range(1, 24000);
                if ($urandom_range(0, 1)) begin
                    cruise_target = -cruise_target;
                end
            end
            r = $urandom_range(0, 99);
            spread = (r < 70) ? 400 : ((r < 95) ? 4000 : 60000);
            add_req(cruise_target,
                    cruise_target + int'($urandom_range(0, 2 * spread)) - spread, 1'b0);
        end
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= spff_pkg::REG_KP_GAIN;
        cfg_wr_data <= kp;
        @(posedge aclk);
        cfg_index   <= spff_pkg::REG_KI_GAIN;
        cfg_wr_data <= ki;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained();
        while (open_reqs != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && cfg_wr_en) begin
            case (cfg_index)
                spff_pkg::REG_KP_GAIN: kp_gain_q16 <= longint'(cfg_wr_data);
                spff_pkg::REG_KI_GAIN: ki_gain_q16 <= longint'(cfg_wr_data);
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin : req_driver
        speed_req_t sent;
        speed_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                sent.tgt  = s_tdata[19:0];
                sent.meas = s_tdata[39:20];
                sent.clr  = s_tdata[40];
                expected_pwm.push_back(step_pwm(sent));
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    s_tdata  <= {7'b0, nxt.clr, nxt.meas, nxt.tgt};
                    s_tvalid <= 1'b1;
                    tx_gap   <= idle_len(tx_quiet, 60);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        pwm_result_t want;
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pwm.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request pending", m_tdata));
                end else begin
                    want = expected_pwm.pop_front();
                    if (m_tdata[12:0] !== want.pwm) begin
                        report_mismatch($sformatf("pwm_command %0d, expected %0d",
                                                  $signed(m_tdata[12:0]), want.pwm));
                    end
                    if (m_tdata[13] !== want.sat) begin
                        report_mismatch($sformatf("output_saturated %b, expected %b",
                                                  m_tdata[13], want.sat));
                    end
                    open_reqs--;
                end
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else begin
                n = idle_len(rx_quiet, 150);
                if (n == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_stall <= n - 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL speed_pi_with_feedforward_unit");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        logic [GAIN_W-1:0] kp_next, ki_next;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        set_gains(24'h040000, 24'hFFFFFF);
        add_req(0, 0, 1'b0);
        add_req(524287, -524288, 1'b0);
        add_req(-524288, 524287, 1'b0);
        add_req(10240, 10240, 1'b0);
        add_req(10241, 10000, 1'b0);
        add_req(12032, 12100, 1'b0);
        add_req(12033, 12033, 1'b0);
        add_req(13952, 13900, 1'b0);
        add_req(14208, 14300, 1'b0);
        add_req(16512, 16512, 1'b0);
        add_req(16513, 16400, 1'b0);
        add_req(-16512, -16600, 1'b0);
        add_req(-10240, -10300, 1'b0);
        add_req(1, 0, 1'b0);
        add_req(-1, 0, 1'b0);
        add_req(5000, 4000, 1'b1);
        add_req(524287, 524287, 1'b1);
        // Feedforward alone lands exactly on the limit: not flagged.
        add_req(524287, 524287, 1'b0);
        // Wind up into positive saturation, then pull back with a negative error.
        add_req(20000, 0, 1'b0);
        add_req(20000, 0, 1'b0);
        add_req(20000, 0, 1'b0);
        add_req(20000, 30000, 1'b0);
        add_req(-20000, 0, 1'b0);
        add_req(-20000, 0, 1'b0);
        add_req(-20000, -30000, 1'b0);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin kp_next = 24'h000000; ki_next = 24'h000000; end
                1: begin kp_next = 24'hFFFFFF; ki_next = 24'hFFFFFF; end
                2: begin kp_next = 24'h010000; ki_next = 24'h000800; end
                3: begin kp_next = 24'h000000; ki_next = 24'hFFFFFF; end
                4: begin kp_next = 24'hFFFFFF; ki_next = 24'h000000; end
                5: begin
                    kp_next = GAIN_W'($urandom_range(0, 24'h3FFFFF));
                    ki_next = GAIN_W'($urandom_range(0, 24'h3FFFFF));
                end
                default: begin
                    kp_next = GAIN_W'($urandom);
                    ki_next = GAIN_W'($urandom);
                end
            endcase
            set_gains(kp_next, ki_next);
            repeat (ITEMS_PER_PHASE) add_random_req();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_pwm.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_pwm.size()));
        end
        if (mismatches == 0) begin
            $display("PASS speed_pi_with_feedforward_unit");
        end else begin
            $display("FAIL speed_pi_with_feedforward_unit");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/spff_pkg.sv
rtl/core/speed_pi_with_feedforward_unit.sv
sim/tb_speed_pi_with_feedforward_unit.sv
